@@ src/kfos_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfos_pkg: shared types and constants of the key frame overlap selector
// Field widths, index width, queue sizing, register codes and the beat that
// travels from the classifying front end to the ranking back end.
// ----------------------------------------------------------------------------
package kfos_pkg;

	localparam int INDEX_BITS  = 20;
	localparam int SHIFT_W     = 24;
	localparam int COUNT_W     = 16;
	localparam int KEY_W       = 20;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam int RESIZE_W = (INDEX_BITS > KEY_W) ? INDEX_BITS : KEY_W;

	localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LIMIT  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LIMIT = 1'd1;

	localparam logic [SHIFT_W-1:0] LOW_LIMIT_RESET  = '0;
	localparam logic [SHIFT_W-1:0] HIGH_LIMIT_RESET = '1;

	typedef logic [INDEX_BITS-1:0] idx_t;
	typedef logic [SHIFT_W-1:0]    shift_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [KEY_W-1:0]      key_t;

	// One classified candidate
	typedef struct packed {
		shift_t shift;
		count_t count;
		logic   in_range;
		logic   close;
		logic   eof;
	} item_t;

	// Index to output key width: truncate or zero-extend
	function automatic key_t to_key(input idx_t v);
		logic [RESIZE_W-1:0] w;
		w = '0;
		w[INDEX_BITS-1:0] = v;
		return w[KEY_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ src/kfos_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfos_front: candidate classifier
// Accepts candidate beats, tracks the zero-count run and marks each beat as
// closing, in range and last, then pushes it into the queue.
// ----------------------------------------------------------------------------
module kfos_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire  kfos_pkg::shift_t   shift,
	input  wire  kfos_pkg::count_t   match_count,
	input  wire                      end_of_frames,
	input  wire  kfos_pkg::shift_t   low_limit,
	input  wire  kfos_pkg::shift_t   high_limit,
	input  wire                      q_full,
	output logic                     q_push,
	output kfos_pkg::item_t          q_item
);
	import kfos_pkg::*;

	logic zero_seen_q;
	logic count_zero;
	logic over_high;
	logic close;

	assign count_zero = (match_count == '0);
	assign over_high  = (shift > high_limit);
	assign close      = (count_zero && zero_seen_q) || over_high;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.shift    = shift;
		q_item.count    = match_count;
		q_item.in_range = (shift >= low_limit);
		q_item.close    = close;
		q_item.eof      = end_of_frames;
	end

	// Drop the zero-count history whenever the run ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_seen_q <= 1'b0;
		end else if (q_push) begin
			zero_seen_q <= (close || end_of_frames) ? 1'b0 : count_zero;
		end
	end

endmodule
`default_nettype wire

@@ src/kfos_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfos_queue: short FIFO between front and back
// Holds classified beats so that either side can stall on its own.
// ----------------------------------------------------------------------------
module kfos_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire kfos_pkg::item_t push_item,
	input  wire                pop,
	output logic               head_valid,
	output kfos_pkg::item_t    head_item,
	output logic               full
);
	import kfos_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_pop;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_item  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/kfos_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfos_back: ranking and key frame update
// Ranks kept candidates against the best so far and, at the end of a run,
// loads the new key frame index, or done, into the output register.
// ----------------------------------------------------------------------------
module kfos_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	input  wire kfos_pkg::item_t q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire                  out_stall,
	output kfos_pkg::key_t       key_index,
	output logic                 done_res
);
	import kfos_pkg::*;

	idx_t   cur_key_q;
	idx_t   pos_q;
	idx_t   best_off_q;
	shift_t best_shift_q;
	count_t best_count_q;
	logic   best_inr_q;
	logic   any_kept_q;
	logic   out_valid_q;
	key_t   out_key_q;
	logic   out_done_q;

	logic   slot_free;
	logic   emit;
	logic   keep;
	logic   take;
	idx_t   next_off;
	logic   next_any;
	idx_t   next_key;

	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = q_item.close || q_item.eof;
	assign q_pop     = q_valid && (!emit || slot_free);
	assign keep      = !q_item.close;

	always_comb begin
		if (!any_kept_q) begin
			take = 1'b1;
		end else if (best_inr_q && q_item.in_range) begin
			take = (best_count_q < q_item.count);
		end else if (!best_inr_q && !q_item.in_range) begin
			take = (best_shift_q < q_item.shift);
		end else begin
			take = q_item.in_range;
		end
	end

	assign next_off = (keep && take) ? pos_q : best_off_q;
	assign next_any = any_kept_q || keep;
	assign next_key = cur_key_q + next_off + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_key_q    <= '0;
			pos_q        <= '0;
			best_off_q   <= '0;
			best_shift_q <= '0;
			best_count_q <= '0;
			best_inr_q   <= 1'b0;
			any_kept_q   <= 1'b0;
		end else if (q_pop) begin
			if (emit) begin
				if (next_any) begin
					cur_key_q <= next_key;
				end
				pos_q        <= '0;
				best_off_q   <= '0;
				best_shift_q <= '0;
				best_count_q <= '0;
				best_inr_q   <= 1'b0;
				any_kept_q   <= 1'b0;
			end else begin
				if (take) begin
					best_off_q   <= pos_q;
					best_shift_q <= q_item.shift;
					best_count_q <= q_item.count;
					best_inr_q   <= q_item.in_range;
				end
				any_kept_q <= 1'b1;
				pos_q      <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= q_pop && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_key_q  <= to_key(next_any ? next_key : cur_key_q);
			out_done_q <= !next_any;
		end
	end

	assign out_valid = out_valid_q;
	assign key_index = out_key_q;
	assign done_res  = out_done_q;

endmodule
`default_nettype wire

@@ src/key_frame_overlap_selector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// key_frame_overlap_selector: picks the next key frame after the current one
// Candidate frames arrive in order as a median shift and a match count; at
// the end of each run the index of the new key frame, or done, is returned.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   shift, match_count, end_of_frames
//   result    out        out_valid/out_stall key_index, done_res
//   config    in         cfg_we              cfg_index, cfg_data
//
// One candidate beat is taken every cycle while in_stall is low; the front
// classifies it in the cycle of acceptance and writes it into the queue, and
// the back ranks it from the queue head and registers the result.
// The four-entry queue between front and back sets how long input keeps
// flowing while results are stalled; in_stall rises only when it is full.
// Reset clears the limits to their defaults, frame 0 as key and an empty run.
// ----------------------------------------------------------------------------
module key_frame_overlap_selector (
	input  wire                          clk,
	input  wire                          arst_n,
	// candidate input
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  kfos_pkg::shift_t       shift,
	input  wire  kfos_pkg::count_t       match_count,
	input  wire                          end_of_frames,
	// result output
	output logic                         out_valid,
	input  wire                          out_stall,
	output kfos_pkg::key_t               key_index,
	output logic                         done_res,
	// configuration
	input  wire                          cfg_we,
	input  wire  [kfos_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire  [kfos_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import kfos_pkg::*;

	shift_t low_limit_q;
	shift_t high_limit_q;

	logic  q_push;
	item_t q_push_item;
	logic  q_pop;
	logic  q_head_valid;
	item_t q_head_item;
	logic  q_full;

	// Limit registers: user must write only while block is idle; not enforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= LOW_LIMIT_RESET;
			high_limit_q <= HIGH_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOW_LIMIT:  low_limit_q  <= cfg_data[SHIFT_W-1:0];
				CFG_HIGH_LIMIT: high_limit_q <= cfg_data[SHIFT_W-1:0];
				default:        ;
			endcase
		end
	end

	// Classify each beat against the limits and the zero-count history
	kfos_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.shift         (shift),
		.match_count   (match_count),
		.end_of_frames (end_of_frames),
		.low_limit     (low_limit_q),
		.high_limit    (high_limit_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_push_item)
	);

	// Hold classified beats while the back end waits on the result side
	kfos_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_push_item),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_item  (q_head_item),
		.full       (q_full)
	);

	// Rank kept candidates and advance the key frame at the end of a run
	kfos_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_head_valid),
		.q_item    (q_head_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key_index (key_index),
		.done_res  (done_res)
	);

endmodule
`default_nettype wire

@@ tb/sv/tb_key_frame_overlap_selector.sv @@
// ----------------------------------------------------------------------------
// tb_key_frame_overlap_selector: self-checking bench for the key frame selector
// Drives candidate beats in bursts against a stalling result port. Every
// accepted beat goes through a local model of the run ranking. That model
// yields the key index or done that each closed run must return. A short
// table covers the corner cases first. Random runs follow, under several
// limit settings that include both extremes and crossed limits.
// ----------------------------------------------------------------------------
module tb_key_frame_overlap_selector;
	import kfos_pkg::*;

	localparam int SETTLE_CYCLES = 8;    // queue depth plus pipeline, rounded up
	localparam int SQUEEZE_CYCLES = 300;
	localparam int PHASE_BEATS = 145;
	localparam int NUM_PHASES = 6;
	localparam shift_t SHIFT_MAX = '1;
	localparam count_t COUNT_MAX = '1;

	typedef enum logic {ROW_BEAT, ROW_LIMIT} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_INDEX_W-1:0] reg_idx;
		shift_t                 sh;      // shift, or register value for ROW_LIMIT
		count_t                 cnt;
		logic                   eof;
		logic                   fixed;   // expected result typed in below
		key_t                   key;
		logic                   fin;
	} stim_row_t;

	typedef struct packed {
		key_t key;
		logic fin;
	} key_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	shift_t                 shift;
	count_t                 match_count;
	logic                   end_of_frames;
	logic                   out_valid;
	logic                   out_stall;
	key_t                   key_index;
	logic                   done_res;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Local copy of the limits and of the run being ranked
	shift_t pred_low, pred_high;
	idx_t   cur_key, run_pos, best_off;
	shift_t best_sh;
	count_t best_cnt;
	logic   best_inr, zero_prev, kept_any;

	key_result_t pending_keys[$];
	key_result_t oldest;
	stim_row_t   corner_rows[$];
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned beats_sent = 0;
	shift_t      last_shift = '0;
	count_t      last_count = '0;
	logic        squeeze_req = 1'b0;

	key_frame_overlap_selector DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.shift        (shift),
		.match_count  (match_count),
		.end_of_frames(end_of_frames),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_index    (key_index),
		.done_res     (done_res),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t  %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic clear_run();
		run_pos = '0;
		best_off = '0;
		best_sh = '0;
		best_cnt = '0;
		best_inr = 1'b0;
		zero_prev = 1'b0;
		kept_any = 1'b0;
	endtask

	// Rank one accepted candidate; report whether it ends the run and, if so,
	// the key index (or done) that the block must return for that run.
	task automatic track_key_frame(input shift_t s, input count_t c, input logic eof,
			output logic emit, output key_t key, output logic fin);
		logic closes, inr, take;
		closes = 1'b0;
		// a zero count closes only when the previous candidate was also zero
		if (c == '0) begin
			if (zero_prev)
				closes = 1'b1;
			zero_prev = 1'b1;
		end else begin
			zero_prev = 1'b0;
		end
		if (s > pred_high)
			closes = 1'b1;
		if (!closes) begin
			inr = (s >= pred_low) && (s <= pred_high);
			if (!kept_any)
				take = 1'b1;
			else if (best_inr && inr)
				take = best_cnt < c;
			else if (!best_inr && !inr)
				take = best_sh < s;
			else
				take = inr;
			// strict compares above: on a tie the earlier candidate holds
			if (take) begin
				best_off = run_pos;
				best_sh = s;
				best_cnt = c;
				best_inr = inr;
			end
			kept_any = 1'b1;
			run_pos = run_pos + 1'b1;
		end
		emit = closes || eof;
		fin = 1'b0;
		key = '0;
		if (emit) begin
			// an empty run leaves the key frame where it was and reports done
			if (kept_any)
				cur_key = cur_key + best_off + 1'b1;
			else
				fin = 1'b1;
			key = key_t'(cur_key);
			clear_run();
		end
	endtask

	// Offer one beat, idling between bursts, and hold it until accepted
	task automatic send_item(input shift_t s, input count_t c, input logic e,
			input logic fixed, input key_t fkey, input logic ffin);
		int unsigned gap;
		logic        emit, fin;
		key_t        key;
		key_result_t exp_res;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		shift <= s;
		match_count <= c;
		end_of_frames <= e;
		do
			@(posedge clk);
		while (in_stall);
		// the beat went in at this edge: update the model in acceptance order
		track_key_frame(s, c, e, emit, key, fin);
		if (fixed) begin
			exp_res.key = fkey;
			exp_res.fin = ffin;
			pending_keys.insert(pending_keys.size(), exp_res);
		end else if (emit) begin
			exp_res.key = key;
			exp_res.fin = fin;
			pending_keys.insert(pending_keys.size(), exp_res);
		end
		last_shift = s;
		last_count = c;
		beats_sent++;
	endtask

	// Write one limit once the block has drained
	task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx, input shift_t value);
		in_valid <= 1'b0;
		while (pending_keys.size() != 0)
			@(posedge clk);
		// beats that close nothing may still sit in the queue
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LOW_LIMIT)
			pred_low = value;
		else
			pred_high = value;
	endtask

	task automatic add_beat(input shift_t s, input count_t c, input logic e,
			input logic fixed, input key_t k, input logic f);
		stim_row_t r;
		r.kind = ROW_BEAT;
		r.reg_idx = CFG_LOW_LIMIT;
		r.sh = s;
		r.cnt = c;
		r.eof = e;
		r.fixed = fixed;
		r.key = k;
		r.fin = f;
		corner_rows.insert(corner_rows.size(), r);
	endtask

	task automatic add_limit(input logic [CFG_INDEX_W-1:0] idx, input shift_t value);
		stim_row_t r;
		r.kind = ROW_LIMIT;
		r.reg_idx = idx;
		r.sh = value;
		r.cnt = '0;
		r.eof = 1'b0;
		r.fixed = 1'b0;
		r.key = '0;
		r.fin = 1'b0;
		corner_rows.insert(corner_rows.size(), r);
	endtask

	// Shift for a kept candidate: in the window, on a limit, below it or repeated
	function automatic shift_t pick_kept_shift();
		case ($urandom_range(0, 7))
			0, 1, 2: return shift_t'($urandom_range(pred_low, pred_high));
			3:       return pred_low;
			4:       return pred_high;
			5:       return (pred_low == '0) ? '0 : shift_t'($urandom_range(0, pred_low - 1));
			6:       return last_shift;
			default: return shift_t'($urandom_range(0, pred_high));
		endcase
	endfunction

	// Shift beyond the high limit; saturates when the limit is at its maximum
	function automatic shift_t pick_closing_shift();
		if (pred_high == SHIFT_MAX)
			return SHIFT_MAX;
		return shift_t'($urandom_range(pred_high + 1, SHIFT_MAX));
	endfunction

	function automatic count_t pick_count();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return last_count;
			2:       return COUNT_MAX;
			3:       return count_t'($urandom_range(0, COUNT_MAX));
			default: return count_t'($urandom_range(1, 50));
		endcase
	endfunction

	// One well-formed run with random content, closed in one of four ways
	task automatic send_run();
		int unsigned len;
		len = $urandom_range(1, 10);
		repeat (len)
			send_item(pick_kept_shift(), pick_count(), 1'b0, 1'b0, '0, 1'b0);
		case ($urandom_range(0, 3))
			0: send_item(pick_closing_shift(), pick_count(), 1'b0, 1'b0, '0, 1'b0);
			1: begin
				// two zero counts in a row: the second closes unless the first already did
				send_item(pick_kept_shift(), '0, 1'b0, 1'b0, '0, 1'b0);
				send_item(pick_kept_shift(), '0, 1'b0, 1'b0, '0, 1'b0);
			end
			2: send_item(pick_kept_shift(), pick_count(), 1'b1, 1'b0, '0, 1'b0);
			default: send_item(pick_closing_shift(), pick_count(), 1'b1, 1'b0, '0, 1'b0);
		endcase
	endtask

	// Result port: pick a stall pattern per stretch, plus one long hold-off
	initial begin
		int unsigned squeeze_left, mode, mode_left;
		squeeze_left = 0;
		mode = 0;
		mode_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_left > 0) begin
				squeeze_left--;
				out_stall <= 1'b1;
			end else if (squeeze_req) begin
				// hold results back so the queue fills and in_stall rises
				squeeze_req = 1'b0;
				squeeze_left = SQUEEZE_CYCLES;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Compare every result beat with the oldest outstanding expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_keys.size() == 0) begin
				report_mismatch("result beat with nothing pending", 32'(key_index), '0);
			end else begin
				oldest = pending_keys.pop_front();
				if (key_index !== oldest.key)
					report_mismatch("key_index", 32'(key_index), 32'(oldest.key));
				if (done_res !== oldest.fin)
					report_mismatch("done_res", 32'(done_res), 32'(oldest.fin));
			end
		end
	end

	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		shift_t lo, hi;
		int unsigned phase_start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		shift = '0;
		match_count = '0;
		end_of_frames = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pred_low = LOW_LIMIT_RESET;
		pred_high = HIGH_LIMIT_RESET;
		cur_key = '0;
		clear_run();

		// Corner table. Reset limits: a lone beat with eof, a second zero count
		// closing the run, and eof right after a close.
		add_beat(24'h0, 16'h0, 1'b1, 1'b1, 20'd1, 1'b0);
		add_beat(SHIFT_MAX, COUNT_MAX, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h0, 16'h0, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h5, 16'h0, 1'b0, 1'b1, 20'd2, 1'b0);
		add_beat(24'ha, 16'h0, 1'b1, 1'b1, 20'd3, 1'b0);
		// Narrow window: empty runs report done, with and without eof
		add_limit(CFG_LOW_LIMIT, 24'h100);
		add_limit(CFG_HIGH_LIMIT, 24'h1000);
		add_beat(24'h1001, 16'd5, 1'b0, 1'b1, 20'd3, 1'b1);
		add_beat(24'h1001, 16'h0, 1'b1, 1'b1, 20'd3, 1'b1);
		// Ranking: larger shift out of range, ties held, in range beats out of
		// range, higher count in range, then a close on an over-limit shift
		add_beat(24'h50, 16'd100, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h80, 16'd1, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h80, 16'd9, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h200, 16'd3, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h300, 16'd3, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h100, 16'd7, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h1000, 16'd7, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h90, 16'd999, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h1001, 16'd1, 1'b0, 1'b0, '0, 1'b0);
		// Crossed limits: nothing is in range, so the largest shift wins
		add_limit(CFG_LOW_LIMIT, 24'h800);
		add_limit(CFG_HIGH_LIMIT, 24'h400);
		add_beat(24'h500, 16'd3, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h300, 16'd50, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h400, 16'd1, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h100, 16'd9, 1'b1, 1'b0, '0, 1'b0);
		// Both limits at the top: only the maximum shift is in range
		add_limit(CFG_LOW_LIMIT, SHIFT_MAX);
		add_limit(CFG_HIGH_LIMIT, SHIFT_MAX);
		add_beat(SHIFT_MAX, 16'd1, 1'b0, 1'b0, '0, 1'b0);
		add_beat(24'h0, 16'd2, 1'b1, 1'b0, '0, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_rows[i]) begin
			if (corner_rows[i].kind == ROW_LIMIT)
				write_limit(corner_rows[i].reg_idx, corner_rows[i].sh);
			else
				send_item(corner_rows[i].sh, corner_rows[i].cnt, corner_rows[i].eof,
					corner_rows[i].fixed, corner_rows[i].key, corner_rows[i].fin);
		end

		// Random phases, each under its own pair of limits
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					lo = '0;
					hi = SHIFT_MAX;
				end
				1: begin
					lo = shift_t'($urandom_range(0, 24'h8000));
					hi = shift_t'($urandom_range(lo + 1, lo + 24'h40000));
				end
				2: begin
					lo = SHIFT_MAX;
					hi = SHIFT_MAX;
				end
				3: begin
					lo = '0;
					hi = '0;
				end
				4: begin
					hi = shift_t'($urandom_range(24'h10, 24'h4000));
					lo = shift_t'($urandom_range(hi + 1, hi + 24'h4000));
				end
				default: begin
					lo = shift_t'($urandom_range(0, SHIFT_MAX));
					hi = shift_t'($urandom_range(lo, SHIFT_MAX));
				end
			endcase
			write_limit(CFG_LOW_LIMIT, lo);
			write_limit(CFG_HIGH_LIMIT, hi);
			if (ph == 1)
				squeeze_req = 1'b1;
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				if ($urandom_range(0, 4) != 0) begin
					send_run();
				end else begin
					// noise: any field value, eof now and then
					repeat ($urandom_range(1, 4)) begin
						send_item(shift_t'($urandom_range(0, SHIFT_MAX)),
							count_t'($urandom_range(0, COUNT_MAX)),
							($urandom_range(0, 7) == 0), 1'b0, '0, 1'b0);
					end
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_keys.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
